FILE: src/dwl_pkg.sv
package dwl_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int WAIT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [7:0] POOL_FIRST_RESET = 8'd100;
    localparam logic [7:0] POOL_LAST_RESET = 8'd250;

    typedef enum logic [3:0] {
        V_DONE      = 4'd0,
        V_FULL      = 4'd1,
        V_EXHAUSTED = 4'd2,
        V_UNKNOWN   = 4'd3,
        V_OFFER     = 4'd4,
        V_ACK       = 4'd5,
        V_NAK       = 4'd6,
        V_OTHER     = 4'd7,
        V_FOUND     = 4'd8,
        V_REBOUND   = 4'd9,
        V_IGNORED   = 4'd10
    } t_verdict;

    typedef enum logic [2:0] {
        A_JOIN     = 3'd0,
        A_LEAVE    = 3'd1,
        A_LOOKUP   = 3'd2,
        A_DISCOVER = 3'd3,
        A_REQUEST  = 3'd4,
        A_DECLINE  = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        R_SERVER_ADDRESS = 2'd0,
        R_POOL_FIRST     = 2'd1,
        R_POOL_LAST      = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic [2:0]  action;
        logic [47:0] chaddr;
        logic [31:0] requested_address;
        logic        requested_present;
        logic [31:0] current_client_address;
        logic [31:0] named_server;
        logic        named_server_present;
    } t_in;

    typedef struct packed {
        logic [3:0]  verdict;
        logic [31:0] address;
    } t_out;

    typedef struct packed {
        logic new_bind;
        logic set_addr;
        logic set_active;
        logic active_val;
        logic set_age;
    } t_cell_wr;

    typedef struct packed {
        logic             valid;
        logic [31:0]      age;
        logic [IDX_W-1:0] idx;
    } t_chain;

endpackage

FILE: src/dwl_cell.sv
module dwl_cell import dwl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  t_cell_wr         i_wr,
    input  logic [47:0]      i_mac,
    input  logic [31:0]      i_addr,
    input  logic [31:0]      i_age,
    input  logic [47:0]      i_mac_key,
    input  logic [31:0]      i_addr_key,
    input  t_chain           i_chain,
    output t_chain           o_chain,
    output logic             o_mac_hit,
    output logic             o_addr_hit,
    output logic             o_used,
    output logic [31:0]      o_addr
);

    logic [47:0] r_mac;
    logic [31:0] r_addr;
    logic [31:0] r_age;
    logic        r_used;
    logic        r_active;
    t_chain      r_chain;
    t_chain      n_chain;
    logic        take;

    // The oldest inactive entry travels down the row; ties keep the lower index.
    assign take = r_used && !r_active && (!i_chain.valid || (r_age < i_chain.age));

    always_comb begin
        if (take) begin
            n_chain = '{valid: 1'b1, age: r_age, idx: i_idx};
        end else begin
            n_chain = i_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= 1'b0;
            r_active <= 1'b0;
            r_chain  <= '0;
        end else begin
            r_chain <= n_chain;
            if (i_wr.new_bind) begin
                r_used <= 1'b1;
            end
            if (i_wr.set_active) begin
                r_active <= i_wr.active_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.new_bind) begin
            r_mac <= i_mac;
        end
        if (i_wr.set_addr) begin
            r_addr <= i_addr;
        end
        if (i_wr.set_age) begin
            r_age <= i_age;
        end
    end

    assign o_chain    = r_chain;
    assign o_mac_hit  = r_used && (r_mac == i_mac_key);
    assign o_addr_hit = r_used && (r_addr == i_addr_key);
    assign o_used     = r_used;
    assign o_addr     = r_addr;

endmodule

FILE: src/dhcp_whitelist_lease_table.sv
// Lease table for a whitelist DHCP server: one request in, one result out, and a new request is
// taken only while the block is idle. Lookup, leave, join of a known client and the direct cases
// of discover, request and decline pass through accept, decode and result hand-over. A discover
// with a hint and a request for a new address add a held-address check state before hand-over.
// A join of a new client or a decline walks the pool one host octet per cycle and tries up to
// (pool_last - pool_first + 1) candidates. When the table has no free slot, the oldest inactive
// entry is found by a row of TABLE_ENTRIES cells that passes the best candidate one cell per
// cycle. A result that is not yet taken holds the block in its hand-over state.
module dhcp_whitelist_lease_table import dwl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_VICTIM, S_ALLOC_INIT, S_ALLOC_STEP, S_CHECK, S_DONE
    } t_state;

    t_state           r_state;
    t_in              r_req;
    t_out             r_res;
    t_out             r_out;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_k;
    logic [IDX_W-1:0] r_slot;
    logic             r_mode_join;
    logic [31:0]      r_key;
    logic [7:0]       r_cursor;
    logic [8:0]       r_cnt;
    logic [WAIT_W-1:0] r_wait;
    logic [31:0]      r_age_cnt;
    logic [31:0]      r_server;
    logic [7:0]       r_first;
    logic [7:0]       r_last;

    t_cell_wr         wr [TABLE_ENTRIES];
    t_chain           chain [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] mac_hit;
    logic [TABLE_ENTRIES-1:0] addr_hit;
    logic [TABLE_ENTRIES-1:0] used;
    logic [31:0]      cell_addr [TABLE_ENTRIES];

    logic             found;
    logic [IDX_W-1:0] k;
    logic             free_any;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] sel_k;
    logic [31:0]      k_addr;
    logic [31:0]      cand;
    logic [31:0]      addr_key;
    logic [31:0]      wr_addr;
    logic             held;
    logic             key_in_pool;
    logic             succ;
    logic             bump;
    logic [7:0]       cursor_next;
    logic             have;
    logic [31:0]      want;

    assign chain[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        dwl_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_idx      (IDX_W'(g)),
            .i_wr       (wr[g]),
            .i_mac      (r_req.chaddr),
            .i_addr     (wr_addr),
            .i_age      (r_age_cnt + 32'd1),
            .i_mac_key  (r_req.chaddr),
            .i_addr_key (addr_key),
            .i_chain    (chain[g]),
            .o_chain    (chain[g+1]),
            .o_mac_hit  (mac_hit[g]),
            .o_addr_hit (addr_hit[g]),
            .o_used     (used[g]),
            .o_addr     (cell_addr[g])
        );
    end

    always_comb begin
        found    = 1'b0;
        k        = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (mac_hit[i]) begin
                found = 1'b1;
                k     = IDX_W'(i);
            end
            if (!used[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign sel_k       = (r_state == S_DECODE) ? k : r_k;
    assign k_addr      = cell_addr[sel_k];
    assign cand        = {r_server[31:8], r_cursor};
    assign addr_key    = (r_state == S_ALLOC_STEP) ? cand : r_key;
    assign held        = |addr_hit;
    assign key_in_pool = (r_key[31:8] == r_server[31:8]) && (r_key[7:0] >= r_first) &&
                         (r_key[7:0] <= r_last) && (r_key[7:0] != r_server[7:0]);
    assign succ        = (r_cursor != r_server[7:0]) && !held;
    assign cursor_next = (r_cursor >= r_last) ? r_first : r_cursor + 8'd1;
    assign have        = r_req.requested_present || (r_req.current_client_address != 32'd0);
    assign want        = r_req.requested_present ? r_req.requested_address
                                                 : r_req.current_client_address;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            wr[i] = '0;
        end
        wr_addr = r_key;
        bump    = 1'b0;
        case (r_state)
            S_DECODE: begin
                if (found && (r_req.action == A_JOIN)) begin
                    wr[k].set_active = 1'b1;
                    wr[k].active_val = 1'b1;
                    wr[k].set_age    = 1'b1;
                    bump             = 1'b1;
                end else if (found && (r_req.action == A_LEAVE)) begin
                    wr[k].set_active = 1'b1;
                end
            end
            S_ALLOC_STEP: begin
                if (succ) begin
                    wr_addr = cand;
                    if (r_mode_join) begin
                        wr[r_slot] = '{new_bind: 1'b1, set_addr: 1'b1, set_active: 1'b1,
                                       active_val: 1'b1, set_age: 1'b1};
                        bump       = 1'b1;
                    end else begin
                        wr[r_k].set_addr = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (key_in_pool && !held) begin
                    wr[r_k].set_addr = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cursor    <= POOL_FIRST_RESET;
            r_age_cnt   <= '0;
            r_server    <= '0;
            r_first     <= POOL_FIRST_RESET;
            r_last      <= POOL_LAST_RESET;
            r_mode_join <= 1'b0;
            r_wait      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    R_SERVER_ADDRESS: r_server <= i_cfg_data;
                    R_POOL_FIRST:     r_first  <= i_cfg_data[7:0];
                    R_POOL_LAST:      r_last   <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (bump) begin
                r_age_cnt <= r_age_cnt + 32'd1;
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_k <= k;
                    if (r_req.action == A_JOIN) begin
                        if (found) begin
                            r_res   <= '{verdict: V_DONE, address: k_addr};
                            r_state <= S_DONE;
                        end else if (free_any) begin
                            r_slot      <= free_idx;
                            r_mode_join <= 1'b1;
                            r_state     <= S_ALLOC_INIT;
                        end else begin
                            r_wait  <= WAIT_W'(TABLE_ENTRIES);
                            r_state <= S_VICTIM;
                        end
                    end else if (r_req.action > A_DECLINE) begin
                        r_res   <= '{verdict: V_IGNORED, address: 32'd0};
                        r_state <= S_DONE;
                    end else if (!found) begin
                        r_res   <= '{verdict: V_UNKNOWN, address: 32'd0};
                        r_state <= S_DONE;
                    end else begin
                        case (r_req.action)
                            A_LEAVE: begin
                                r_res   <= '{verdict: V_DONE, address: k_addr};
                                r_state <= S_DONE;
                            end
                            A_LOOKUP: begin
                                r_res   <= '{verdict: V_FOUND, address: k_addr};
                                r_state <= S_DONE;
                            end
                            A_DISCOVER: begin
                                if (r_req.requested_present) begin
                                    r_key   <= r_req.requested_address;
                                    r_state <= S_CHECK;
                                end else begin
                                    r_res   <= '{verdict: V_OFFER, address: k_addr};
                                    r_state <= S_DONE;
                                end
                            end
                            A_REQUEST: begin
                                if (r_req.named_server_present &&
                                    (r_req.named_server != r_server)) begin
                                    r_res   <= '{verdict: V_OTHER, address: 32'd0};
                                    r_state <= S_DONE;
                                end else if (!have || (want == k_addr)) begin
                                    r_res   <= '{verdict: V_ACK, address: k_addr};
                                    r_state <= S_DONE;
                                end else begin
                                    r_key   <= want;
                                    r_state <= S_CHECK;
                                end
                            end
                            A_DECLINE: begin
                                if (r_req.requested_present &&
                                    (r_req.requested_address == k_addr)) begin
                                    r_mode_join <= 1'b0;
                                    r_state     <= S_ALLOC_INIT;
                                end else begin
                                    r_res   <= '{verdict: V_IGNORED, address: 32'd0};
                                    r_state <= S_DONE;
                                end
                            end
                            default: begin
                                r_res   <= '{verdict: V_IGNORED, address: 32'd0};
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_VICTIM: begin
                    if (r_wait == '0) begin
                        if (chain[TABLE_ENTRIES].valid) begin
                            r_slot      <= chain[TABLE_ENTRIES].idx;
                            r_mode_join <= 1'b1;
                            r_state     <= S_ALLOC_INIT;
                        end else begin
                            r_res   <= '{verdict: V_FULL, address: 32'd0};
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_wait <= r_wait - WAIT_W'(1);
                    end
                end
                S_ALLOC_INIT: begin
                    if (r_last < r_first) begin
                        r_res   <= '{verdict: V_EXHAUSTED, address: 32'd0};
                        r_state <= S_DONE;
                    end else begin
                        if ((r_cursor < r_first) || (r_cursor > r_last)) begin
                            r_cursor <= r_first;
                        end
                        r_cnt   <= {1'b0, r_last} - {1'b0, r_first} + 9'd1;
                        r_state <= S_ALLOC_STEP;
                    end
                end
                S_ALLOC_STEP: begin
                    r_cursor <= cursor_next;
                    r_cnt    <= r_cnt - 9'd1;
                    if (succ) begin
                        r_res   <= '{verdict: r_mode_join ? V_DONE : V_REBOUND, address: cand};
                        r_state <= S_DONE;
                    end else if (r_cnt == 9'd1) begin
                        r_res   <= '{verdict: V_EXHAUSTED, address: 32'd0};
                        r_state <= S_DONE;
                    end
                end
                S_CHECK: begin
                    r_state <= S_DONE;
                    if (r_req.action == A_DISCOVER) begin
                        r_res <= '{verdict: V_OFFER,
                                   address: (key_in_pool && !held) ? r_key : k_addr};
                    end else if (key_in_pool && !held) begin
                        r_res <= '{verdict: V_ACK, address: r_key};
                    end else begin
                        r_res <= '{verdict: V_NAK, address: 32'd0};
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while busy");

    a_age_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_age_cnt != $past(r_age_cnt))) |->
        (r_age_cnt == $past(r_age_cnt) + 32'd1))
        else $error("age counter skipped");

    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.verdict <= V_IGNORED))
        else $error("verdict out of range");

endmodule

FILE: dv/tb_top.sv
module tb_top;
    import dwl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] A_SPARE_LO = 3'd6;
    localparam logic [2:0] A_SPARE_HI = 3'd7;
    localparam int IDLE_LIMIT = 4000;
    localparam int MAC_SET = 24;

    typedef struct {
        t_in  req;
        bit   typed;
        t_out res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    dhcp_whitelist_lease_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the lease table and its settings.
    logic [31:0] srv_addr;
    logic [7:0]  pool_lo;
    logic [7:0]  pool_hi;
    logic [47:0] lease_mac [TABLE_ENTRIES];
    logic [31:0] lease_addr [TABLE_ENTRIES];
    bit          lease_used [TABLE_ENTRIES];
    bit          lease_active [TABLE_ENTRIES];
    logic [31:0] lease_age [TABLE_ENTRIES];
    logic [7:0]  cursor;
    logic [31:0] age_ctr;

    t_out        pending_replies [$];
    t_row        directed [$];
    logic [47:0] macs [MAC_SET];
    int          errors;
    int          idle_cycles;
    bit          calm;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int find_lease(logic [47:0] mac);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (lease_used[i] && lease_mac[i] == mac) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic bit addr_taken(logic [31:0] a);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (lease_used[i] && lease_addr[i] == a) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit in_pool(logic [31:0] a);
        return a[31:8] == srv_addr[31:8] && a[7:0] >= pool_lo && a[7:0] <= pool_hi
            && a[7:0] != srv_addr[7:0];
    endfunction

    function automatic bit next_free(output logic [31:0] fresh);
        int span;
        logic [7:0] h;
        logic [31:0] cand;
        fresh = '0;
        if (pool_hi < pool_lo) begin
            return 1'b0;
        end
        if (cursor < pool_lo || cursor > pool_hi) begin
            cursor = pool_lo;
        end
        span = int'(pool_hi) - int'(pool_lo) + 1;
        for (int n = 0; n < span; n++) begin
            h = cursor;
            cursor = (cursor >= pool_hi) ? pool_lo : cursor + 8'd1;
            if (h == srv_addr[7:0]) begin
                continue;
            end
            cand = {srv_addr[31:8], h};
            if (!addr_taken(cand)) begin
                fresh = cand;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_out lease_reply(t_in x);
        t_out r;
        int k;
        int slot;
        int victim;
        logic [31:0] fresh;
        logic [31:0] want;
        bit have;
        r.verdict = V_IGNORED;
        r.address = '0;
        k = find_lease(x.chaddr);
        if (x.action > A_DECLINE) begin
            r.verdict = V_IGNORED;
        end else if (x.action == A_JOIN) begin
            if (k >= 0) begin
                lease_active[k] = 1'b1;
                age_ctr++;
                lease_age[k] = age_ctr;
                r.verdict = V_DONE;
                r.address = lease_addr[k];
            end else begin
                slot = -1;
                victim = -1;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (!lease_used[i]) begin
                        slot = i;
                        break;
                    end
                    if (!lease_active[i] && (victim < 0 || lease_age[i] < lease_age[victim])) begin
                        victim = i;
                    end
                end
                if (slot < 0) begin
                    slot = victim;
                end
                if (slot < 0) begin
                    r.verdict = V_FULL;
                end else if (!next_free(fresh)) begin
                    r.verdict = V_EXHAUSTED;
                end else begin
                    lease_mac[slot] = x.chaddr;
                    lease_addr[slot] = fresh;
                    lease_used[slot] = 1'b1;
                    lease_active[slot] = 1'b1;
                    age_ctr++;
                    lease_age[slot] = age_ctr;
                    r.verdict = V_DONE;
                    r.address = fresh;
                end
            end
        end else if (k < 0) begin
            r.verdict = V_UNKNOWN;
        end else if (x.action == A_LEAVE) begin
            lease_active[k] = 1'b0;
            r.verdict = V_DONE;
            r.address = lease_addr[k];
        end else if (x.action == A_LOOKUP) begin
            r.verdict = V_FOUND;
            r.address = lease_addr[k];
        end else if (x.action == A_DISCOVER) begin
            if (x.requested_present && in_pool(x.requested_address)
                    && !addr_taken(x.requested_address)) begin
                lease_addr[k] = x.requested_address;
            end
            r.verdict = V_OFFER;
            r.address = lease_addr[k];
        end else if (x.action == A_REQUEST) begin
            if (x.named_server_present && x.named_server != srv_addr) begin
                r.verdict = V_OTHER;
            end else begin
                have = 1'b0;
                want = '0;
                if (x.requested_present) begin
                    want = x.requested_address;
                    have = 1'b1;
                end else if (x.current_client_address != '0) begin
                    want = x.current_client_address;
                    have = 1'b1;
                end
                if (have && want != lease_addr[k]) begin
                    if (in_pool(want) && !addr_taken(want)) begin
                        lease_addr[k] = want;
                        r.verdict = V_ACK;
                        r.address = want;
                    end else begin
                        r.verdict = V_NAK;
                    end
                end else begin
                    r.verdict = V_ACK;
                    r.address = lease_addr[k];
                end
            end
        end else begin
            if (x.requested_present && x.requested_address == lease_addr[k]) begin
                if (next_free(fresh)) begin
                    lease_addr[k] = fresh;
                    r.verdict = V_REBOUND;
                    r.address = fresh;
                end else begin
                    r.verdict = V_EXHAUSTED;
                end
            end
        end
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send(t_in x, bit typed, t_out res);
        int gap;
        t_out predicted;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        predicted = lease_reply(x);
        pending_replies.push_back(typed ? res : predicted);
        i_in_valid <= 1'b1;
        i_in <= x;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(t_reg_index idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            R_SERVER_ADDRESS: srv_addr = data;
            R_POOL_FIRST: pool_lo = data[7:0];
            default: pool_hi = data[7:0];
        endcase
    endtask

    task automatic quiesce();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_in make_req(logic [2:0] act, logic [47:0] mac, logic [31:0] ra, bit rp,
                                     logic [31:0] ci, logic [31:0] ns, bit np);
        t_in x;
        x.action = act;
        x.chaddr = mac;
        x.requested_address = ra;
        x.requested_present = rp;
        x.current_client_address = ci;
        x.named_server = ns;
        x.named_server_present = np;
        return x;
    endfunction

    function automatic t_out reply(t_verdict v, logic [31:0] a);
        t_out r;
        r.verdict = v;
        r.address = a;
        return r;
    endfunction

    function automatic logic [31:0] pick_addr(logic [47:0] mac);
        int k;
        int r;
        k = find_lease(mac);
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return {srv_addr[31:8], 8'($urandom_range(0, 255))};
        end else if (r < 7 && k >= 0) begin
            return lease_addr[k];
        end else if (r < 8 && pool_lo <= pool_hi) begin
            return {srv_addr[31:8], 8'($urandom_range(pool_lo, pool_hi))};
        end
        return $urandom;
    endfunction

    function automatic t_in random_req();
        t_in x;
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) x.action = A_JOIN;
        else if (r < 42) x.action = A_LEAVE;
        else if (r < 50) x.action = A_LOOKUP;
        else if (r < 65) x.action = A_DISCOVER;
        else if (r < 84) x.action = A_REQUEST;
        else if (r < 97) x.action = A_DECLINE;
        else x.action = $urandom_range(0, 1) ? A_SPARE_LO : A_SPARE_HI;
        x.chaddr = ($urandom_range(0, 9) == 0) ? {16'($urandom), 32'($urandom)}
                                               : macs[$urandom_range(0, MAC_SET - 1)];
        x.requested_address = pick_addr(x.chaddr);
        x.requested_present = $urandom_range(0, 3) != 0;
        x.current_client_address = $urandom_range(0, 1) ? '0 : pick_addr(x.chaddr);
        x.named_server = ($urandom_range(0, 9) < 7) ? srv_addr : 32'($urandom);
        x.named_server_present = 1'($urandom_range(0, 1));
        return x;
    endfunction

    task automatic run_phase(logic [31:0] srv, logic [7:0] lo, logic [7:0] hi, int count);
        quiesce();
        write_reg(R_SERVER_ADDRESS, srv);
        write_reg(R_POOL_FIRST, {24'd0, lo});
        write_reg(R_POOL_LAST, {24'd0, hi});
        i_cfg_we <= 1'b0;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                calm = $urandom_range(0, 3) == 0;
            end
            send(random_req(), 1'b0, reply(V_IGNORED, '0));
        end
    endtask

    initial begin
        logic [47:0] mac_a;
        logic [47:0] mac_b;
        logic [47:0] mac_c;
        errors = 0;
        calm = 1'b0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= R_SERVER_ADDRESS;
        i_cfg_data <= '0;
        srv_addr = '0;
        pool_lo = POOL_FIRST_RESET;
        pool_hi = POOL_LAST_RESET;
        cursor = POOL_FIRST_RESET;
        age_ctr = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            lease_used[i] = 1'b0;
            lease_active[i] = 1'b0;
            lease_mac[i] = '0;
            lease_addr[i] = '0;
            lease_age[i] = '0;
        end
        for (int i = 0; i < MAC_SET; i++) begin
            macs[i] = {16'($urandom), 32'($urandom)};
        end
        macs[0] = '0;
        macs[1] = '1;
        mac_a = 48'h0002_0000_00aa;
        mac_b = 48'h0002_0000_00bb;
        mac_c = 48'h0002_0000_00cc;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back('{make_req(A_LOOKUP, mac_a, 0, 0, 0, 0, 0), 1, reply(V_UNKNOWN, 0)});
        directed.push_back('{make_req(A_JOIN, mac_a, 0, 0, 0, 0, 0), 1, reply(V_DONE, 100)});
        directed.push_back('{make_req(A_JOIN, mac_b, 0, 0, 0, 0, 0), 1, reply(V_DONE, 101)});
        directed.push_back('{make_req(A_JOIN, mac_a, 0, 0, 0, 0, 0), 1, reply(V_DONE, 100)});
        directed.push_back('{make_req(A_LOOKUP, mac_a, 0, 0, 0, 0, 0), 1, reply(V_FOUND, 100)});
        directed.push_back('{make_req(A_LEAVE, mac_b, 0, 0, 0, 0, 0), 1, reply(V_DONE, 101)});
        directed.push_back('{make_req(A_LEAVE, mac_c, 0, 0, 0, 0, 0), 1, reply(V_UNKNOWN, 0)});
        directed.push_back('{make_req(A_DISCOVER, mac_a, 150, 1, 0, 0, 0), 1,
                             reply(V_OFFER, 150)});
        directed.push_back('{make_req(A_DISCOVER, mac_a, '1, 1, 0, 0, 0), 1, reply(V_OFFER, 150)});
        directed.push_back('{make_req(A_REQUEST, mac_a, 0, 0, 0, 5, 1), 1, reply(V_OTHER, 0)});
        directed.push_back('{make_req(A_REQUEST, mac_a, 0, 0, 0, '1, 0), 1, reply(V_ACK, 150)});
        directed.push_back('{make_req(A_REQUEST, mac_a, 101, 1, 0, 0, 1), 1, reply(V_NAK, 0)});
        directed.push_back('{make_req(A_REQUEST, mac_a, 0, 0, 120, 0, 0), 1, reply(V_ACK, 120)});
        directed.push_back('{make_req(A_DECLINE, mac_a, 120, 1, 0, 0, 0), 1,
                             reply(V_REBOUND, 102)});
        directed.push_back('{make_req(A_DECLINE, mac_a, 5, 1, 0, 0, 0), 1, reply(V_IGNORED, 0)});
        directed.push_back('{make_req(A_SPARE_LO, mac_a, 0, 0, 0, 0, 0), 1, reply(V_IGNORED, 0)});
        directed.push_back('{make_req(A_SPARE_HI, '1, '1, 1, '1, '1, 1), 1, reply(V_IGNORED, 0)});
        directed.push_back('{make_req(A_DISCOVER, mac_c, 0, 0, 0, 0, 0), 1, reply(V_UNKNOWN, 0)});
        directed.push_back('{make_req(A_JOIN, '1, '1, 1, '1, '1, 1), 1, reply(V_DONE, 103)});
        directed.push_back('{make_req(A_JOIN, '0, 0, 0, 0, 0, 0), 1, reply(V_DONE, 104)});
        directed.push_back('{make_req(A_REQUEST, '1, 32'h0000_00fa, 1, 0, 0, 0), 0,
                             reply(V_IGNORED, 0)});
        directed.push_back('{make_req(A_DISCOVER, '0, 32'h0000_00fb, 1, 0, 0, 0), 0,
                             reply(V_IGNORED, 0)});
        foreach (directed[i]) begin
            send(directed[i].req, directed[i].typed, directed[i].res);
        end

        run_phase(32'hc0a8_0101, 8'd100, 8'd250, 300);
        run_phase(32'hffff_ffff, 8'd1, 8'd254, 300);
        run_phase(32'h0a00_0005, 8'd3, 8'd8, 300);
        run_phase(32'h0a00_0005, 8'd9, 8'd4, 150);
        run_phase(32'h0a00_00fe, 8'd254, 8'd254, 150);
        run_phase(32'h0000_0000, 8'd1, 8'd1, 150);
        run_phase(32'hc0a8_0101, 8'd20, 8'd40, 330);

        quiesce();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        int stall;
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_replies.size() == 0) begin
                report("unexpected reply", {28'd0, o_out.verdict}, '0);
            end else begin
                want = pending_replies.pop_front();
                if (o_out.verdict !== want.verdict) begin
                    report("verdict", {28'd0, o_out.verdict}, {28'd0, want.verdict});
                end
                if (o_out.address !== want.address) begin
                    report("address", o_out.address, want.address);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || pending_replies.size() == 0 && !i_in_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
